FILE: hdl/idps_pkg.sv
// ----------------------------------------------------------------------------
// Ignition debounce and power state package
// Shared types, register indexes and constants for the ignition debounce
// and power state unit.
// ----------------------------------------------------------------------------
package idps_pkg;

    // Width of the timestamp fields on the ports.
    localparam int NOW_W              = 48;
    // Default width of the internal time arithmetic.
    localparam int TIME_WIDTH_DEFAULT = 48;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PARK_S      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH = CFG_IDX_W'(2);

    // Defaults, also used when the debounce time or park timeout is written with zero.
    localparam logic [15:0] DEFAULT_DEBOUNCE_MS = 16'd300;
    localparam logic [15:0] DEFAULT_PARK_S      = 16'd120;
    localparam logic [9:0]  MS_PER_S            = 10'd1000;

    // Park timeout in milliseconds: 65535 * 1000 fits in 26 bits.
    localparam int PARK_MS_W = 26;
    localparam logic [PARK_MS_W-1:0] DEFAULT_PARK_MS = PARK_MS_W'(120000);

    typedef enum logic [1:0] {
        MODE_DRIVE = 2'd0,
        MODE_AWAKE = 2'd1,
        MODE_SLEEP = 2'd2
    } power_mode_t;

    typedef struct packed {
        logic             pin_level;
        logic [NOW_W-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        power_mode_t      power_mode;
        logic             ignition_on;
        logic [NOW_W-1:0] last_change_ms;
        logic             mode_changed;
    } out_item_t;

    // Effective configuration handed to the poll logic.
    typedef struct packed {
        logic [15:0]          settle_ms;
        logic [PARK_MS_W-1:0] park_ms;
        logic                 active_high;
    } cfg_t;

endpackage

FILE: hdl/idps_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the debounce time, the park timeout (kept in milliseconds) and the
// pin polarity. Zero writes to the debounce time and park timeout fall back to the defaults.
// ----------------------------------------------------------------------------
module idps_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [idps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [idps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output idps_pkg::cfg_t                  cfg
);
    import idps_pkg::*;

    logic [15:0]          debounce_reg, debounce_next;
    logic [PARK_MS_W-1:0] park_ms_reg,  park_ms_next;
    logic                 active_reg,   active_next;
    logic [15:0]          park_s;

    // Decode the write; the park timeout is scaled to milliseconds here so
    // that the poll path only compares.
    always_comb
    begin
        debounce_next = debounce_reg;
        park_ms_next  = park_ms_reg;
        active_next   = active_reg;
        park_s        = (cfg_wdata == 16'd0) ? DEFAULT_PARK_S : cfg_wdata;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE_MS:
                    debounce_next = (cfg_wdata == 16'd0) ? DEFAULT_DEBOUNCE_MS : cfg_wdata;
                REG_PARK_S:
                    park_ms_next = PARK_MS_W'(park_s * MS_PER_S);
                REG_ACTIVE_HIGH:
                    active_next = cfg_wdata[0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEFAULT_DEBOUNCE_MS;
            park_ms_reg  <= DEFAULT_PARK_MS;
            active_reg   <= 1'b1;
        end
        else
        begin
            debounce_reg <= debounce_next;
            park_ms_reg  <= park_ms_next;
            active_reg   <= active_next;
        end
    end

    assign cfg.settle_ms   = debounce_reg;
    assign cfg.park_ms     = park_ms_reg;
    assign cfg.active_high = active_reg;

endmodule

FILE: hdl/idps_in_stage.sv
// ----------------------------------------------------------------------------
// Poll input register
// Captures one poll transaction and holds it until the poll logic takes it.
// ----------------------------------------------------------------------------
module idps_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  idps_pkg::in_item_t in_data,
    output logic               item_valid,
    output idps_pkg::in_item_t item,
    input  logic               item_take
);
    import idps_pkg::*;

    logic     valid_reg, valid_next;
    in_item_t item_reg;

    // The register is free when empty or when its poll leaves this cycle.
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = in_valid || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hdl/idps_core.sv
// ----------------------------------------------------------------------------
// Debounce and power mode logic
// Applies one poll to the debouncer and power mode state combinationally
// and writes the result transaction into the output register.
// ----------------------------------------------------------------------------
module idps_core #(
    parameter int TIME_WIDTH = idps_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  idps_pkg::cfg_t      cfg,
    input  logic                item_valid,
    input  idps_pkg::in_item_t  item,
    output logic                item_take,
    output logic                out_valid,
    input  logic                out_ready,
    output idps_pkg::out_item_t out_data
);
    import idps_pkg::*;

    // Poll state.
    logic                  started_reg,    started_next;
    logic                  cand_level_reg, cand_level_next;
    logic [TIME_WIDTH-1:0] cand_since_reg, cand_since_next;
    logic                  deb_level_reg,  deb_level_next;
    logic [TIME_WIDTH-1:0] off_since_reg,  off_since_next;
    logic                  off_valid_reg,  off_valid_next;
    power_mode_t           mode_reg,       mode_next;
    logic [TIME_WIDTH-1:0] change_reg,     change_next;

    // Output register.
    logic                  out_valid_reg,  out_valid_next;
    out_item_t             result_reg,     result_next;

    logic [TIME_WIDTH+NOW_W-1:0] now_ext;
    logic [TIME_WIDTH+NOW_W-1:0] change_ext;
    logic [TIME_WIDTH-1:0]       now_t;
    logic [TIME_WIDTH-1:0]       cand_elapsed;
    logic [TIME_WIDTH-1:0]       off_elapsed;
    logic                        raw;
    logic                        first;
    logic                        deb_ok;
    logic                        park_ok;
    logic                        fire;
    logic                        changed;

    // Time in the internal width, and elapsed times modulo that width.
    assign now_ext      = {{TIME_WIDTH{1'b0}}, item.now_ms};
    assign now_t        = now_ext[TIME_WIDTH-1:0];
    assign cand_elapsed = now_t - cand_since_reg;
    assign off_elapsed  = now_t - off_since_reg;
    assign deb_ok       = cand_elapsed >= TIME_WIDTH'(cfg.settle_ms);
    assign park_ok      = off_elapsed >= TIME_WIDTH'(cfg.park_ms);

    assign raw   = cfg.active_high ? item.pin_level : !item.pin_level;
    assign first = !started_reg;
    assign fire  = !first && (raw == cand_level_reg) &&
                   (cand_level_reg != deb_level_reg) && deb_ok;

    // A poll moves on when the output register is empty or being drained.
    assign item_take = item_valid && (!out_valid_reg || out_ready);

    // Next state for one poll.
    always_comb
    begin
        started_next    = started_reg;
        cand_level_next = cand_level_reg;
        cand_since_next = cand_since_reg;
        deb_level_next  = deb_level_reg;
        off_since_next  = off_since_reg;
        off_valid_next  = off_valid_reg;
        mode_next       = mode_reg;

        if (first)
        begin
            // The first poll loads the debouncer straight from the pin.
            started_next    = 1'b1;
            cand_level_next = raw;
            cand_since_next = now_t;
            deb_level_next  = raw;
            off_valid_next  = !raw;
            off_since_next  = raw ? '0 : now_t;
            mode_next       = raw ? MODE_DRIVE : MODE_AWAKE;
        end
        else
        begin
            if (raw != cand_level_reg)
            begin
                cand_level_next = raw;
                cand_since_next = now_t;
            end

            if (fire)
            begin
                deb_level_next = cand_level_reg;
                if (cand_level_reg)
                begin
                    off_since_next = '0;
                    off_valid_next = 1'b0;
                    mode_next      = MODE_DRIVE;
                end
                else
                begin
                    off_since_next = now_t;
                    off_valid_next = 1'b1;
                    mode_next      = MODE_AWAKE;
                end
            end
            else if (!deb_level_reg && (mode_reg == MODE_AWAKE) && off_valid_reg && park_ok)
            begin
                mode_next = MODE_SLEEP;
            end
            else if (deb_level_reg && (mode_reg != MODE_DRIVE))
            begin
                mode_next = MODE_DRIVE;
            end
        end

        // No poll can return the mode to where it started, so a differing
        // mode marks every change.
        changed     = (mode_next != mode_reg);
        change_next = changed ? now_t : change_reg;
        change_ext  = {{NOW_W{1'b0}}, change_next};

        result_next.power_mode     = mode_next;
        result_next.ignition_on    = deb_level_next;
        result_next.last_change_ms = change_ext[NOW_W-1:0];
        result_next.mode_changed   = changed;
    end

    assign out_valid_next = item_take || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg    <= 1'b0;
            cand_level_reg <= 1'b0;
            cand_since_reg <= '0;
            deb_level_reg  <= 1'b0;
            off_since_reg  <= '0;
            off_valid_reg  <= 1'b0;
            mode_reg       <= MODE_AWAKE;
            change_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_take)
            begin
                started_reg    <= started_next;
                cand_level_reg <= cand_level_next;
                cand_since_reg <= cand_since_next;
                deb_level_reg  <= deb_level_next;
                off_since_reg  <= off_since_next;
                off_valid_reg  <= off_valid_next;
                mode_reg       <= mode_next;
                change_reg     <= change_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

endmodule

FILE: hdl/ignition_debounce_power_state_unit.sv
// An accepted poll transaction passes the input register and then the result register.
// Throughput: one poll per cycle unless the result side stalls; the debouncer
// and power mode state update combinationally ahead of the result register.
// Back-pressure on the result side stalls the input register and then the input.
// Reset (rst_n, asynchronous, active low) clears the poll state, sets the mode to
// park awake and loads the register defaults 300 ms, 120 s and active-high pin.
// ----------------------------------------------------------------------------
// Ignition debounce and power state unit
// Debounces the ignition pin and tracks drive-active, park-awake and
// park-sleep power modes, one result transaction per poll.
// ----------------------------------------------------------------------------
module ignition_debounce_power_state_unit #(
    parameter int TIME_WIDTH = idps_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  idps_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output idps_pkg::out_item_t             out_data,
    input  logic                            cfg_we,
    input  logic [idps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [idps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import idps_pkg::*;

    cfg_t     cfg;
    logic     item_valid;
    logic     item_take;
    in_item_t item;

    // Configuration registers.
    idps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Input register.
    idps_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Poll logic and result register.
    idps_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

FILE: hdl/idps_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the ports of the ignition debounce and power state unit.
// ----------------------------------------------------------------------------
module idps_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input idps_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input idps_pkg::out_item_t out_data
);
    import idps_pkg::*;

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Every accepted poll is followed by a result on offer behind the input and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("no result two cycles after a poll");

    // The input only stalls behind a held result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // Ignition on always means drive active.
    a_ign_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.ignition_on |-> out_data.power_mode == MODE_DRIVE)
        else $error("ignition on outside drive active");

endmodule

bind ignition_debounce_power_state_unit idps_checker u_idps_checker (.*);
